[design/ray_cylinder_intersect_assert.svh]
// assertion macros shared by the ray cylinder intersect checker
`ifndef RAY_CYLINDER_INTERSECT_ASSERT_SVH
`define RAY_CYLINDER_INTERSECT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define RCI_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("ray cylinder intersect check failed");

// next-cycle implication, disabled in reset
`define RCI_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("ray cylinder intersect check failed");

`endif

[design/rci_pkg.sv]
// shared widths, formats and register indexes of the ray cylinder intersect block
`default_nettype none
package rci_pkg;
    localparam int CW     = 32;   // coordinate width, signed fixed point
    localparam int FB     = 16;   // fraction bits
    localparam int RW     = 31;   // radius and height register width
    localparam int EW     = 16;   // parallel threshold register width
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 31;
    localparam int CNT_W  = 2;

    typedef enum logic [CFG_AW-1:0] {
        CFG_RADIUS = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_EPS    = 2'd2
    } cfg_index_t;
endpackage
`default_nettype wire

[design/rci_channels.sv]
// ray input and hit output channel interfaces
`default_nettype none
interface rci_ray_if;
    logic                        valid;
    logic                        ready;
    logic signed [rci_pkg::CW-1:0] origin_x;
    logic signed [rci_pkg::CW-1:0] origin_y;
    logic signed [rci_pkg::CW-1:0] origin_z;
    logic signed [rci_pkg::CW-1:0] dir_x;
    logic signed [rci_pkg::CW-1:0] dir_y;
    logic signed [rci_pkg::CW-1:0] dir_z;
    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    input ready);
    modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    output ready);
endinterface

interface rci_hit_if;
    logic                           valid;
    logic                           ready;
    logic [rci_pkg::CNT_W-1:0]      hit_count;
    logic signed [rci_pkg::CW-1:0]  first_t;
    logic signed [rci_pkg::CW-1:0]  second_t;
    modport source (output valid, hit_count, first_t, second_t, input ready);
    modport sink   (input valid, hit_count, first_t, second_t, output ready);
endinterface
`default_nettype wire

[design/ray_cylinder_intersect.sv]
// Ray against open y-axis cylinder, fully pipelined.
// Stages from input transfer to result valid: 5 setup stages, 64 square-root
// digit stages, 1 root stage, 33 divide stages and 3 finish stages.
// Throughput: one ray per cycle; the whole pipe holds only while the output
// register is full and not taken. Reset clears all valid bits and loads the
// radius 1.0, height 2.0 and threshold 1 lsb defaults.
`default_nettype none
module ray_cylinder_intersect (
    input  logic                              clk,
    input  logic                              rst_n,
    rci_ray_if.sink                           ray,
    rci_hit_if.source                         hit,
    input  logic                              cfg_we,
    input  logic [rci_pkg::CFG_AW-1:0]        cfg_index,
    input  logic [rci_pkg::CFG_DW-1:0]        cfg_data
);
    localparam int SQ_N = 64;   // square root digits
    localparam int DV_N = 32;   // quotient bits below the overflow check
    localparam int DVW  = 96;   // divider remainder width

    typedef struct packed {
        logic               miss;
        logic               hneg;
        logic [63:0]        hmag;
        logic [63:0]        a;
        logic signed [31:0] oy;
        logic signed [31:0] dy;
    } sq_side_t;

    typedef struct packed {
        logic               miss;
        logic [63:0]        a;
        logic signed [31:0] oy;
        logic signed [31:0] dy;
    } dv_side_t;

    // signed magnitude sum of (na, hm) and (sb, s)
    function automatic logic [65:0] sm_root(input logic na, input logic [63:0] hm,
                                            input logic sb, input logic [63:0] s);
        logic [64:0] m;
        logic        n;
        begin
            if (na == sb) begin
                n = na;
                m = {1'b0, hm} + {1'b0, s};
            end else if (hm >= s) begin
                n = na;
                m = {1'b0, hm - s};
            end else begin
                n = sb;
                m = {1'b0, s - hm};
            end
            sm_root = {n, m};
        end
    endfunction

    // saturate a quotient magnitude to the signed coordinate range
    function automatic logic [31:0] sat_root(input logic neg, input logic ovf,
                                             input logic [31:0] q);
        begin
            if (!neg)
                sat_root = (ovf || q[31]) ? 32'h7fff_ffff : q;
            else if (ovf || q > 32'h8000_0000)
                sat_root = 32'h8000_0000;
            else
                sat_root = ~q + 32'd1;
        end
    endfunction

    logic adv;
    logic out_vld_reg;

    // configuration registers
    logic [rci_pkg::RW-1:0] radius_reg;
    logic [rci_pkg::RW-1:0] height_reg;
    logic [rci_pkg::EW-1:0] eps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 31'd65536;
            height_reg <= 31'd131072;
            eps_reg    <= 16'd1;
        end
        else if (cfg_we)
        begin
            unique case (rci_pkg::cfg_index_t'(cfg_index))
                rci_pkg::CFG_RADIUS: radius_reg <= cfg_data;
                rci_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                rci_pkg::CFG_EPS:    eps_reg    <= cfg_data[rci_pkg::EW-1:0];
                default: ;
            endcase
        end
    end

    // global advance: the pipe moves whenever the output can take a result
    assign adv       = !out_vld_reg || hit.ready;
    assign ray.ready = adv;

    // stage 1: products of the components
    logic [31:0] mox, moz, mdx, mdz;
    assign mox = ray.origin_x[31] ? (~ray.origin_x + 32'd1) : ray.origin_x;
    assign moz = ray.origin_z[31] ? (~ray.origin_z + 32'd1) : ray.origin_z;
    assign mdx = ray.dir_x[31] ? (~ray.dir_x + 32'd1) : ray.dir_x;
    assign mdz = ray.dir_z[31] ? (~ray.dir_z + 32'd1) : ray.dir_z;

    logic               s1_vld_reg;
    logic [63:0]        s1_xx_reg, s1_zz_reg, s1_oxx_reg, s1_ozz_reg, s1_r2_reg;
    logic signed [63:0] s1_hx_reg, s1_hz_reg;
    logic signed [31:0] s1_oy_reg, s1_dy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (adv)
            s1_vld_reg <= ray.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_xx_reg  <= {32'd0, mdx} * {32'd0, mdx};
            s1_zz_reg  <= {32'd0, mdz} * {32'd0, mdz};
            s1_oxx_reg <= {32'd0, mox} * {32'd0, mox};
            s1_ozz_reg <= {32'd0, moz} * {32'd0, moz};
            s1_r2_reg  <= {33'd0, radius_reg} * {33'd0, radius_reg};
            s1_hx_reg  <= ray.origin_x * ray.dir_x;
            s1_hz_reg  <= ray.origin_z * ray.dir_z;
            s1_oy_reg  <= ray.origin_y;
            s1_dy_reg  <= ray.dir_y;
        end
    end

    // stage 2: a, half linear term, c and the parallel test
    logic [63:0]        s2_a_next, s2_sq_next;
    logic signed [64:0] s2_hsum;
    logic [64:0]        s2_hneg_val;
    assign s2_a_next   = s1_xx_reg + s1_zz_reg;
    assign s2_sq_next  = s1_oxx_reg + s1_ozz_reg;
    assign s2_hsum     = {s1_hx_reg[63], s1_hx_reg} + {s1_hz_reg[63], s1_hz_reg};
    assign s2_hneg_val = ~s2_hsum + 65'd1;

    logic               s2_vld_reg, s2_miss_reg, s2_hneg_reg, s2_cneg_reg;
    logic [63:0]        s2_a_reg, s2_hmag_reg, s2_cmag_reg;
    logic signed [31:0] s2_oy_reg, s2_dy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else if (adv)
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_a_reg    <= s2_a_next;
            s2_miss_reg <= (s2_a_next == 64'd0) ||
                           (s2_a_next < {32'd0, eps_reg, 16'd0});
            s2_hneg_reg <= s2_hsum[64];
            s2_hmag_reg <= s2_hsum[64] ? s2_hneg_val[63:0] : s2_hsum[63:0];
            s2_cneg_reg <= s2_sq_next < s1_r2_reg;
            s2_cmag_reg <= (s2_sq_next < s1_r2_reg) ? (s1_r2_reg - s2_sq_next)
                                                    : (s2_sq_next - s1_r2_reg);
            s2_oy_reg   <= s1_oy_reg;
            s2_dy_reg   <= s1_dy_reg;
        end
    end

    // stage 3: 32 by 32 partial products of h*h and a*c
    logic               s3_vld_reg;
    sq_side_t           s3_side_reg;
    logic               s3_cneg_reg;
    logic [63:0]        s3_hll_reg, s3_hlh_reg, s3_hhh_reg;
    logic [63:0]        s3_all_reg, s3_alh_reg, s3_ahl_reg, s3_ahh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_vld_reg <= 1'b0;
        else if (adv)
            s3_vld_reg <= s2_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_side_reg <= '{miss: s2_miss_reg, hneg: s2_hneg_reg, hmag: s2_hmag_reg,
                             a: s2_a_reg, oy: s2_oy_reg, dy: s2_dy_reg};
            s3_cneg_reg <= s2_cneg_reg;
            s3_hll_reg  <= {32'd0, s2_hmag_reg[31:0]}  * {32'd0, s2_hmag_reg[31:0]};
            s3_hlh_reg  <= {32'd0, s2_hmag_reg[31:0]}  * {32'd0, s2_hmag_reg[63:32]};
            s3_hhh_reg  <= {32'd0, s2_hmag_reg[63:32]} * {32'd0, s2_hmag_reg[63:32]};
            s3_all_reg  <= {32'd0, s2_a_reg[31:0]}     * {32'd0, s2_cmag_reg[31:0]};
            s3_alh_reg  <= {32'd0, s2_a_reg[31:0]}     * {32'd0, s2_cmag_reg[63:32]};
            s3_ahl_reg  <= {32'd0, s2_a_reg[63:32]}    * {32'd0, s2_cmag_reg[31:0]};
            s3_ahh_reg  <= {32'd0, s2_a_reg[63:32]}    * {32'd0, s2_cmag_reg[63:32]};
        end
    end

    // stage 4: sum the partial products
    logic        s4_vld_reg;
    sq_side_t    s4_side_reg;
    logic        s4_cneg_reg;
    logic [127:0] s4_h2_reg, s4_ac_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_vld_reg <= 1'b0;
        else if (adv)
            s4_vld_reg <= s3_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_side_reg <= s3_side_reg;
            s4_cneg_reg <= s3_cneg_reg;
            s4_h2_reg   <= {s3_hhh_reg, 64'd0} + {31'd0, s3_hlh_reg, 33'd0} +
                           {64'd0, s3_hll_reg};
            s4_ac_reg   <= {s3_ahh_reg, 64'd0} + {32'd0, s3_alh_reg, 32'd0} +
                           {32'd0, s3_ahl_reg, 32'd0} + {64'd0, s3_all_reg};
        end
    end

    // stage 5: discriminant and the negative test
    logic         s5_vld_reg;
    sq_side_t     s5_side_reg;
    logic [127:0] s5_disc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_vld_reg <= 1'b0;
        else if (adv)
            s5_vld_reg <= s4_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_side_reg <= '{miss: s4_side_reg.miss ||
                                   (!s4_cneg_reg && (s4_h2_reg < s4_ac_reg)),
                             hneg: s4_side_reg.hneg, hmag: s4_side_reg.hmag,
                             a: s4_side_reg.a, oy: s4_side_reg.oy, dy: s4_side_reg.dy};
            s5_disc_reg <= s4_cneg_reg ? (s4_h2_reg + s4_ac_reg)
                                       : (s4_h2_reg - s4_ac_reg);
        end
    end

    // square root, one result bit per stage, msb first
    logic         sq_vld_reg  [SQ_N];
    sq_side_t     sq_side_reg [SQ_N];
    logic [127:0] sq_rem_reg  [SQ_N];
    logic [63:0]  sq_res_reg  [SQ_N];

    for (genvar k = 0; k < SQ_N; k++)
    begin : g_sq
        localparam int B = SQ_N - 1 - k;
        logic         vld_in;
        sq_side_t     side_in;
        logic [127:0] rem_in;
        logic [63:0]  res_in;
        logic [127:0] trial;

        if (k == 0)
        begin : g_head
            assign vld_in  = s5_vld_reg;
            assign side_in = s5_side_reg;
            assign rem_in  = s5_disc_reg;
            assign res_in  = 64'd0;
        end
        else
        begin : g_body
            assign vld_in  = sq_vld_reg[k-1];
            assign side_in = sq_side_reg[k-1];
            assign rem_in  = sq_rem_reg[k-1];
            assign res_in  = sq_res_reg[k-1];
        end

        assign trial = ({64'd0, res_in} << (B + 1)) | (128'd1 << (2 * B));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_vld_reg[k] <= 1'b0;
            else if (adv)
                sq_vld_reg[k] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_side_reg[k] <= side_in;
                if (rem_in >= trial)
                begin
                    sq_rem_reg[k] <= rem_in - trial;
                    sq_res_reg[k] <= res_in | (64'd1 << B);
                end
                else
                begin
                    sq_rem_reg[k] <= rem_in;
                    sq_res_reg[k] <= res_in;
                end
            end
        end
    end

    // root numerators: -h - s and -h + s
    logic [65:0] rt_n0, rt_n1;
    assign rt_n0 = sm_root(!sq_side_reg[SQ_N-1].hneg, sq_side_reg[SQ_N-1].hmag,
                           1'b1, sq_res_reg[SQ_N-1]);
    assign rt_n1 = sm_root(!sq_side_reg[SQ_N-1].hneg, sq_side_reg[SQ_N-1].hmag,
                           1'b0, sq_res_reg[SQ_N-1]);

    logic        rt_vld_reg;
    dv_side_t    rt_side_reg;
    logic        rt_neg0_reg, rt_neg1_reg;
    logic [64:0] rt_mag0_reg, rt_mag1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rt_vld_reg <= 1'b0;
        else if (adv)
            rt_vld_reg <= sq_vld_reg[SQ_N-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rt_side_reg <= '{miss: sq_side_reg[SQ_N-1].miss, a: sq_side_reg[SQ_N-1].a,
                             oy: sq_side_reg[SQ_N-1].oy, dy: sq_side_reg[SQ_N-1].dy};
            rt_neg0_reg <= rt_n0[65];
            rt_mag0_reg <= rt_n0[64:0];
            rt_neg1_reg <= rt_n1[65];
            rt_mag1_reg <= rt_n1[64:0];
        end
    end

    // divide stage 0: quotient overflow past 32 bits
    logic [DVW-1:0] dv_num0, dv_num1, dv_lim;
    assign dv_num0 = {15'd0, rt_mag0_reg, 16'd0};
    assign dv_num1 = {15'd0, rt_mag1_reg, 16'd0};
    assign dv_lim  = {rt_side_reg.a, 32'd0};

    logic           dv_vld_reg  [DV_N+1];
    dv_side_t       dv_side_reg [DV_N+1];
    logic [DVW-1:0] dv_rem0_reg [DV_N+1];
    logic [DVW-1:0] dv_rem1_reg [DV_N+1];
    logic [31:0]    dv_q0_reg   [DV_N+1];
    logic [31:0]    dv_q1_reg   [DV_N+1];
    logic           dv_ovf0_reg [DV_N+1];
    logic           dv_ovf1_reg [DV_N+1];
    logic           dv_neg0_reg [DV_N+1];
    logic           dv_neg1_reg [DV_N+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_vld_reg[0] <= 1'b0;
        else if (adv)
            dv_vld_reg[0] <= rt_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_side_reg[0] <= rt_side_reg;
            dv_rem0_reg[0] <= dv_num0;
            dv_rem1_reg[0] <= dv_num1;
            dv_q0_reg[0]   <= 32'd0;
            dv_q1_reg[0]   <= 32'd0;
            dv_ovf0_reg[0] <= dv_num0 >= dv_lim;
            dv_ovf1_reg[0] <= dv_num1 >= dv_lim;
            dv_neg0_reg[0] <= rt_neg0_reg;
            dv_neg1_reg[0] <= rt_neg1_reg;
        end
    end

    // restoring divide, one quotient bit per stage for both roots
    for (genvar j = 1; j <= DV_N; j++)
    begin : g_dv
        localparam int I = DV_N - j;
        logic [DVW-1:0] dsh;
        assign dsh = {32'd0, dv_side_reg[j-1].a} << I;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_vld_reg[j] <= 1'b0;
            else if (adv)
                dv_vld_reg[j] <= dv_vld_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_side_reg[j] <= dv_side_reg[j-1];
                dv_ovf0_reg[j] <= dv_ovf0_reg[j-1];
                dv_ovf1_reg[j] <= dv_ovf1_reg[j-1];
                dv_neg0_reg[j] <= dv_neg0_reg[j-1];
                dv_neg1_reg[j] <= dv_neg1_reg[j-1];
                if (dv_rem0_reg[j-1] >= dsh)
                begin
                    dv_rem0_reg[j] <= dv_rem0_reg[j-1] - dsh;
                    dv_q0_reg[j]   <= dv_q0_reg[j-1] | (32'd1 << I);
                end
                else
                begin
                    dv_rem0_reg[j] <= dv_rem0_reg[j-1];
                    dv_q0_reg[j]   <= dv_q0_reg[j-1];
                end
                if (dv_rem1_reg[j-1] >= dsh)
                begin
                    dv_rem1_reg[j] <= dv_rem1_reg[j-1] - dsh;
                    dv_q1_reg[j]   <= dv_q1_reg[j-1] | (32'd1 << I);
                end
                else
                begin
                    dv_rem1_reg[j] <= dv_rem1_reg[j-1];
                    dv_q1_reg[j]   <= dv_q1_reg[j-1];
                end
            end
        end
    end

    // saturate both roots
    logic               st_vld_reg;
    dv_side_t           st_side_reg;
    logic signed [31:0] st_t0_reg, st_t1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_vld_reg <= 1'b0;
        else if (adv)
            st_vld_reg <= dv_vld_reg[DV_N];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_side_reg <= dv_side_reg[DV_N];
            st_t0_reg   <= sat_root(dv_neg0_reg[DV_N], dv_ovf0_reg[DV_N], dv_q0_reg[DV_N]);
            st_t1_reg   <= sat_root(dv_neg1_reg[DV_N], dv_ovf1_reg[DV_N], dv_q1_reg[DV_N]);
        end
    end

    // y offsets along the ray at both roots
    logic               yp_vld_reg, yp_miss_reg;
    logic signed [31:0] yp_t0_reg, yp_t1_reg, yp_oy_reg;
    logic signed [63:0] yp_p0_reg, yp_p1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            yp_vld_reg <= 1'b0;
        else if (adv)
            yp_vld_reg <= st_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            yp_miss_reg <= st_side_reg.miss;
            yp_t0_reg   <= st_t0_reg;
            yp_t1_reg   <= st_t1_reg;
            yp_oy_reg   <= st_side_reg.oy;
            yp_p0_reg   <= st_t0_reg * st_side_reg.dy;
            yp_p1_reg   <= st_t1_reg * st_side_reg.dy;
        end
    end

    // height test and result selection
    logic signed [63:0] y_base, y0, y1, y_half;
    logic               keep0, keep1;
    assign y_base = {{16{yp_oy_reg[31]}}, yp_oy_reg, 16'd0};
    assign y0     = y_base + yp_p0_reg;
    assign y1     = y_base + yp_p1_reg;
    assign y_half = {18'd0, height_reg, 15'd0};
    assign keep0  = !yp_miss_reg && (y0 >= -y_half) && (y0 <= y_half);
    assign keep1  = !yp_miss_reg && (y1 >= -y_half) && (y1 <= y_half) &&
                    (yp_t1_reg != yp_t0_reg);

    logic [rci_pkg::CNT_W-1:0] out_cnt_reg;
    logic signed [31:0]        out_first_reg, out_second_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= yp_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_cnt_reg    <= {1'b0, keep0} + {1'b0, keep1};
            out_first_reg  <= keep0 ? yp_t0_reg : (keep1 ? yp_t1_reg : 32'sd0);
            out_second_reg <= (keep0 && keep1) ? yp_t1_reg : 32'sd0;
        end
    end

    assign hit.valid     = out_vld_reg;
    assign hit.hit_count = out_cnt_reg;
    assign hit.first_t   = out_first_reg;
    assign hit.second_t  = out_second_reg;
endmodule
`default_nettype wire

[design/rci_checker.sv]
// port-level checks of the ray cylinder intersect block and their binding
`default_nettype none
`include "ray_cylinder_intersect_assert.svh"
module rci_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  hit_count,
    input logic [31:0] first_t,
    input logic [31:0] second_t
);
    // at most two hits
    `RCI_ASSERT_IMP(a_count_range, clk, rst_n, out_valid, hit_count != 2'd3)
    // a miss carries zero roots
    `RCI_ASSERT_IMP(a_miss_zero, clk, rst_n, out_valid && hit_count == 2'd0,
                    first_t == 32'd0 && second_t == 32'd0)
    // a single hit leaves the second root clear
    `RCI_ASSERT_IMP(a_single_zero, clk, rst_n, out_valid && hit_count == 2'd1,
                    second_t == 32'd0)
    // an empty output slot always lets a ray in
    `RCI_ASSERT_IMP(a_ready_free, clk, rst_n, !out_valid, in_ready)
    // a stalled result holds
    `RCI_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                    out_valid && $stable(hit_count) && $stable(first_t) &&
                    $stable(second_t))
endmodule

bind ray_cylinder_intersect rci_checker u_rci_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (ray.ready),
    .out_valid (hit.valid),
    .out_ready (hit.ready),
    .hit_count (hit.hit_count),
    .first_t   (hit.first_t),
    .second_t  (hit.second_t)
);
`default_nettype wire
